// ===== rtl/erc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_pkg
// Shared constants for the epoch reclaim sequence clock: item field widths
// and operation codes.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CPU_IX_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BUDGET_W = 32;
  localparam int unsigned SEQ_STEP = 2;

  localparam logic [MODE_W-1:0] MODE_ENTER    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEAVE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEFERRED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POLL     = 3'd4;

endpackage

// ===== rtl/erc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_if
// Valid/ready channels of the sequence clock: request items, result items
// and the deferral reload write port.
// ----------------------------------------------------------------------------
interface erc_in_if;
  logic                              valid;
  logic                              ready;
  logic [erc_pkg::MODE_W-1:0]        mode;
  logic [erc_pkg::CPU_IX_W-1:0]      cpu_index;
  logic [erc_pkg::DATA_W-1:0]        goal_seq;
  logic [erc_pkg::BUDGET_W-1:0]      step_cost;

  modport source (output valid, mode, cpu_index, goal_seq, step_cost, input ready);
  modport sink   (input valid, mode, cpu_index, goal_seq, step_cost, output ready);
endinterface

interface erc_out_if;
  logic                              valid;
  logic                              ready;
  logic [erc_pkg::DATA_W-1:0]        seq_value;
  logic                              goal_reached;
  logic                              misuse;

  modport source (output valid, seq_value, goal_reached, misuse, input ready);
  modport sink   (input valid, seq_value, goal_reached, misuse, output ready);
endinterface

interface erc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [erc_pkg::BUDGET_W-1:0]      deferral_reload;

  modport source (output valid, deferral_reload, input ready);
  modport sink   (input valid, deferral_reload, output ready);
endinterface

// ===== rtl/erc_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_row_mem
// Per-CPU row store, one write and one read port, registered read data.
// Rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module erc_row_mem #(
  parameter  int DEPTH = 8,
  parameter  int WIDTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_r;
  logic             data_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        data_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = data_vld_r ? data_r : '0;

endmodule

// ===== rtl/epoch_reclaim_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_reclaim_clock
// Safe-reclamation sequence clock with per-CPU reader slots and budgets.
// ----------------------------------------------------------------------------
// One item is worked at a time. Enter, leave, advance, deferred advance and
// ignored items are accepted, then finished in the execute state (a
// read-modify-write of the CPU row in the slot memory for enter, leave and
// deferred advance). A poll reads the slot memory one row per cycle through
// its single read port to find the oldest active reader. A new item is
// taken while the previous result waits in the output register; a result
// leaves only when that register is free. Slot rows reset to idle through
// per-row valid bits, so there is no clearing pass after reset.
module epoch_reclaim_clock #(
  parameter int NUM_CPUS = 8,
  parameter int SEQ_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  erc_in_if.sink    in_if,
  erc_out_if.source out_if,
  erc_cfg_if.sink   cfg_if
);

  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNT_W = $clog2(NUM_CPUS + 1);
  localparam int BW    = erc_pkg::BUDGET_W;
  localparam int ROW_W = BW + SEQ_BITS;
  localparam logic [SEQ_BITS-1:0] STEP = SEQ_BITS'(erc_pkg::SEQ_STEP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  function automatic logic seq_le(input logic [SEQ_BITS-1:0] a,
                                  input logic [SEQ_BITS-1:0] b);
    logic [SEQ_BITS-1:0] d;
    d = a - b;
    return (d == '0) || d[SEQ_BITS-1];
  endfunction

  function automatic logic seq_lt(input logic [SEQ_BITS-1:0] a,
                                  input logic [SEQ_BITS-1:0] b);
    logic [SEQ_BITS-1:0] d;
    d = a - b;
    return d[SEQ_BITS-1];
  endfunction

  logic [1:0]                     state_r, state_nxt;
  logic [erc_pkg::MODE_W-1:0]     mode_r, mode_nxt;
  logic                           cpu_ok_r, cpu_ok_nxt;
  logic [CPU_W-1:0]               idx_r, idx_nxt;
  logic [SEQ_BITS-1:0]            goal_r, goal_nxt;
  logic [BW-1:0]                  step_r, step_nxt;
  logic [BW-1:0]                  reload_r, reload_nxt;
  logic [SEQ_BITS-1:0]            ws_r, ws_nxt;
  logic [SEQ_BITS-1:0]            rs_r, rs_nxt;
  logic [SEQ_BITS-1:0]            oldest_r, oldest_nxt;
  logic [CNT_W-1:0]               ptr_r, ptr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [erc_pkg::DATA_W-1:0]     out_seq_r, out_seq_nxt;
  logic                           out_reached_r, out_reached_nxt;
  logic                           out_misuse_r, out_misuse_nxt;

  logic                           in_acc;
  logic                           in_cpu_ok;
  logic                           out_free;
  logic                           mem_rd_en;
  logic [CPU_W-1:0]               mem_rd_addr;
  logic [ROW_W-1:0]               mem_rd_data;
  logic                           mem_wr_en;
  logic [ROW_W-1:0]               mem_wr_data;
  logic [SEQ_BITS-1:0]            row_seq;
  logic [BW-1:0]                  row_budget;
  logic [SEQ_BITS-1:0]            ws_plus;
  logic [SEQ_BITS-1:0]            scan_s;
  logic [SEQ_BITS-1:0]            delta;
  logic [SEQ_BITS-1:0]            rs_raised;

  assign in_if.ready  = rst_n && (state_r == S_IDLE);
  assign cfg_if.ready = rst_n;
  assign in_acc       = in_if.valid && in_if.ready;
  assign in_cpu_ok    = (int'(in_if.cpu_index) < NUM_CPUS);
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid        = out_valid_r;
  assign out_if.seq_value    = out_seq_r;
  assign out_if.goal_reached = out_reached_r;
  assign out_if.misuse       = out_misuse_r;

  assign row_seq    = mem_rd_data[SEQ_BITS-1:0];
  assign row_budget = mem_rd_data[ROW_W-1:SEQ_BITS];
  assign ws_plus    = ws_r + STEP;
  assign scan_s     = seq_lt(row_seq, rs_r) ? rs_r : row_seq;
  assign delta      = goal_r - ws_r;
  assign rs_raised  = seq_le(oldest_r, rs_r) ? rs_r : oldest_r;

  erc_row_mem #(
    .DEPTH (NUM_CPUS),
    .WIDTH (ROW_W)
  ) u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (mem_wr_data)
  );

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    cpu_ok_nxt      = cpu_ok_r;
    idx_nxt         = idx_r;
    goal_nxt        = goal_r;
    step_nxt        = step_r;
    reload_nxt      = cfg_if.valid ? cfg_if.deferral_reload : reload_r;
    ws_nxt          = ws_r;
    rs_nxt          = rs_r;
    oldest_nxt      = oldest_r;
    ptr_nxt         = ptr_r;
    out_valid_nxt   = out_if.ready ? 1'b0 : out_valid_r;
    out_seq_nxt     = out_seq_r;
    out_reached_nxt = out_reached_r;
    out_misuse_nxt  = out_misuse_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;
    mem_wr_en       = 1'b0;
    mem_wr_data     = mem_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_if.mode;
          cpu_ok_nxt = in_cpu_ok;
          idx_nxt    = CPU_W'(in_if.cpu_index);
          goal_nxt   = SEQ_BITS'(in_if.goal_seq);
          step_nxt   = in_if.step_cost;
          if (in_if.mode == erc_pkg::MODE_POLL) begin
            mem_rd_en  = 1'b1;
            mem_rd_addr = '0;
            ptr_nxt    = CNT_W'(1);
            oldest_nxt = ws_r;
            state_nxt  = S_SCAN;
          end else begin
            mem_rd_en   = in_cpu_ok;
            mem_rd_addr = CPU_W'(in_if.cpu_index);
            state_nxt   = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_seq_nxt     = '0;
          out_reached_nxt = 1'b0;
          out_misuse_nxt  = 1'b0;
          state_nxt       = S_IDLE;
          unique case (mode_r)
            erc_pkg::MODE_ENTER: begin
              if (cpu_ok_r) begin
                out_misuse_nxt = (row_seq != '0);
                mem_wr_en      = 1'b1;
                mem_wr_data    = {row_budget, ws_r};
              end
            end
            erc_pkg::MODE_LEAVE: begin
              if (cpu_ok_r) begin
                out_misuse_nxt = (row_seq == '0);
                mem_wr_en      = 1'b1;
                mem_wr_data    = {row_budget, {SEQ_BITS{1'b0}}};
              end
            end
            erc_pkg::MODE_ADVANCE: begin
              ws_nxt      = ws_plus;
              out_seq_nxt = erc_pkg::DATA_W'(ws_plus);
            end
            erc_pkg::MODE_DEFERRED: begin
              if (cpu_ok_r) begin
                mem_wr_en   = 1'b1;
                out_seq_nxt = erc_pkg::DATA_W'(ws_plus);
                if (step_r > row_budget) begin
                  mem_wr_data = {reload_r, row_seq};
                  ws_nxt      = ws_plus;
                end else begin
                  mem_wr_data = {row_budget - step_r, row_seq};
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if ((row_seq != '0) && seq_lt(scan_s, oldest_r)) begin
          oldest_nxt = scan_s;
        end
        if (ptr_r == CNT_W'(NUM_CPUS)) begin
          state_nxt = S_FIN;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = CPU_W'(ptr_r);
          ptr_nxt     = ptr_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_seq_nxt     = '0;
          out_reached_nxt = 1'b0;
          out_misuse_nxt  = 1'b0;
          state_nxt       = S_IDLE;
          priority if (goal_r == '0) begin
            out_misuse_nxt = 1'b1;
          end else if (seq_le(goal_r, rs_r)) begin
            out_reached_nxt = 1'b1;
          end else if ((delta == STEP) && (reload_r != '0)) begin
            out_reached_nxt = 1'b0;
          end else if ((delta != '0) && !delta[SEQ_BITS-1]) begin
            out_reached_nxt = 1'b1;
          end else begin
            rs_nxt          = rs_raised;
            out_reached_nxt = seq_le(goal_r, rs_raised);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reload_r    <= '0;
      ws_r        <= SEQ_BITS'(1);
      rs_r        <= SEQ_BITS'(1);
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      reload_r    <= reload_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    cpu_ok_r      <= cpu_ok_nxt;
    idx_r         <= idx_nxt;
    goal_r        <= goal_nxt;
    step_r        <= step_nxt;
    oldest_r      <= oldest_nxt;
    out_seq_r     <= out_seq_nxt;
    out_reached_r <= out_reached_nxt;
    out_misuse_r  <= out_misuse_nxt;
  end

  a_ws_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (ws_r != $past(ws_r))) |-> (ws_r == $past(ws_r) + STEP))
    else $error("write sequence moved by other than one step");

  a_rs_rises: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (rs_r != $past(rs_r))) |-> seq_lt($past(rs_r), rs_r))
    else $error("read sequence moved backward");

  a_wr_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> ((state_r == S_EXEC) && cpu_ok_r))
    else $error("slot row written outside execute");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((ptr_r != '0) && (ptr_r <= CNT_W'(NUM_CPUS))))
    else $error("scan pointer out of range");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch reclaim sequence clock.
// A short directed table covers reset values, field extremes, misuse, the
// reserved modes and deferral budget rollover. Randomized request streams
// follow under several deferral reload values and idle/stall mixes. Every
// result item is checked in order against the typed expectation of its
// table row or a sequence clock predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCPU           = 8;
  localparam int CLK_HALF       = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 140;
  localparam int NUM_PHASES     = 5;

  localparam logic [erc_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [erc_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [erc_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef logic [erc_pkg::DATA_W-1:0]   seq_t;
  typedef logic [erc_pkg::BUDGET_W-1:0] budget_t;

  typedef struct packed {
    logic [erc_pkg::MODE_W-1:0]   mode;
    logic [erc_pkg::CPU_IX_W-1:0] cpu;
    seq_t                         goal;
    budget_t                      cost;
  } req_t;

  typedef struct packed {
    seq_t seq;
    logic reached;
    logic misuse;
  } rsp_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_RELOAD} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    req_t      req;
    rsp_t      exp;
  } row_t;

  logic clk;
  logic rst_n;

  erc_in_if  in_ch ();
  erc_out_if out_ch ();
  erc_cfg_if cfg_ch ();

  epoch_reclaim_clock dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state
  seq_t    clk_write_seq;
  seq_t    clk_read_seq;
  seq_t    clk_slot [NCPU];
  budget_t clk_budget [NCPU];
  budget_t clk_reload;

  rsp_t pending_results [$];
  row_t directed_rows [$];

  int send_idle_pct;
  int stall_pct;
  bit hold_request;
  int fail_count;
  int n_checked;
  int n_req;
  int n_polls;
  int n_reached;
  int n_misuse;
  int n_advances;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit seq_not_newer(seq_t a, seq_t b);
    seq_t d;
    d = a - b;
    return (d == '0) || d[erc_pkg::DATA_W-1];
  endfunction

  function automatic bit seq_older(seq_t a, seq_t b);
    seq_t d;
    d = a - b;
    return d[erc_pkg::DATA_W-1];
  endfunction

  function automatic rsp_t clock_step(req_t r);
    rsp_t o;
    seq_t delta;
    seq_t oldest;
    seq_t s;
    o = '0;
    case (r.mode)
      erc_pkg::MODE_ENTER: begin
        o.misuse = (clk_slot[r.cpu] != '0);
        clk_slot[r.cpu] = clk_write_seq;
      end
      erc_pkg::MODE_LEAVE: begin
        o.misuse = (clk_slot[r.cpu] == '0);
        clk_slot[r.cpu] = '0;
      end
      erc_pkg::MODE_ADVANCE: begin
        clk_write_seq = clk_write_seq + erc_pkg::SEQ_STEP;
        o.seq = clk_write_seq;
        n_advances++;
      end
      erc_pkg::MODE_DEFERRED: begin
        if (r.cost > clk_budget[r.cpu]) begin
          clk_budget[r.cpu] = clk_reload;
          clk_write_seq = clk_write_seq + erc_pkg::SEQ_STEP;
          o.seq = clk_write_seq;
          n_advances++;
        end else begin
          clk_budget[r.cpu] = clk_budget[r.cpu] - r.cost;
          o.seq = clk_write_seq + erc_pkg::SEQ_STEP;
        end
      end
      erc_pkg::MODE_POLL: begin
        n_polls++;
        if (r.goal == '0) begin
          o.misuse = 1'b1;
        end else if (seq_not_newer(r.goal, clk_read_seq)) begin
          o.reached = 1'b1;
        end else begin
          delta = r.goal - clk_write_seq;
          if (delta == erc_pkg::SEQ_STEP && clk_reload != '0) begin
            o.reached = 1'b0;
          end else if (delta != '0 && !delta[erc_pkg::DATA_W-1]) begin
            // goal past the next advance, or at it with a zero reload: stale, treated as reached
            o.reached = 1'b1;
          end else begin
            oldest = clk_write_seq;
            for (int i = 0; i < NCPU; i++) begin
              if (clk_slot[i] != '0) begin
                s = seq_older(clk_slot[i], clk_read_seq) ? clk_read_seq : clk_slot[i];
                if (seq_older(s, oldest)) oldest = s;
              end
            end
            if (!seq_not_newer(oldest, clk_read_seq)) clk_read_seq = oldest;
            o.reached = seq_not_newer(r.goal, clk_read_seq);
          end
        end
      end
      default: ;
    endcase
    if (o.reached) n_reached++;
    if (o.misuse) n_misuse++;
    return o;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    int   cands [$];
    r.cpu  = erc_pkg::CPU_IX_W'($urandom_range(0, NCPU - 1));
    r.goal = $urandom;
    r.cost = $urandom;
    pick   = $urandom_range(0, 99);
    if (pick < 18) r.mode = erc_pkg::MODE_ENTER;
    else if (pick < 36) r.mode = erc_pkg::MODE_LEAVE;
    else if (pick < 50) r.mode = erc_pkg::MODE_ADVANCE;
    else if (pick < 70) r.mode = erc_pkg::MODE_DEFERRED;
    else if (pick < 96) r.mode = erc_pkg::MODE_POLL;
    else begin
      case ($urandom_range(0, 2))
        0:       r.mode = MODE_RSVD5;
        1:       r.mode = MODE_RSVD6;
        default: r.mode = MODE_RSVD7;
      endcase
    end

    case (r.mode)
      erc_pkg::MODE_ENTER, erc_pkg::MODE_LEAVE: begin
        // mostly well-formed: enter an idle slot, leave an active one
        for (int i = 0; i < NCPU; i++) begin
          if ((clk_slot[i] == '0) == (r.mode == erc_pkg::MODE_ENTER)) cands.push_back(i);
        end
        if (cands.size() > 0 && $urandom_range(0, 99) < 85) begin
          r.cpu = erc_pkg::CPU_IX_W'(cands[$urandom_range(0, cands.size() - 1)]);
        end
      end
      erc_pkg::MODE_DEFERRED: begin
        pick = $urandom_range(0, 99);
        if (pick < 30) r.cost = $urandom_range(0, 3);
        else if (pick < 45) r.cost = '0;
        else if (pick < 55) r.cost = '1;
        else if (pick < 70) r.cost = clk_budget[r.cpu];
        else if (pick < 80) r.cost = clk_budget[r.cpu] + 1;
      end
      erc_pkg::MODE_POLL: begin
        for (int i = 0; i < NCPU; i++) begin
          if (clk_slot[i] != '0) cands.push_back(i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) r.goal = '0;
        else if (pick < 18) r.goal = clk_read_seq - $urandom_range(0, 6);
        else if (pick < 32) r.goal = clk_write_seq;
        else if (pick < 46) r.goal = clk_write_seq + erc_pkg::SEQ_STEP;
        else if (pick < 58) r.goal = clk_write_seq + 2 * $urandom_range(2, 8);
        else if (pick < 76 && cands.size() > 0)
          r.goal = clk_slot[cands[$urandom_range(0, cands.size() - 1)]]
                   + $urandom_range(0, 4);
        else if (pick < 88) r.goal = clk_read_seq + 2 * $urandom_range(0, 4);
        else if (pick < 92) r.goal = clk_write_seq ^ 32'h8000_0000;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_result(rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: unexpected result item seq=%h reached=%b misuse=%b",
                 got.seq, got.reached, got.misuse);
      return;
    end
    want = pending_results.pop_front();
    if (got.seq !== want.seq || got.reached !== want.reached ||
        got.misuse !== want.misuse) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: item %0d expected seq/reached/misuse %h/%b/%b got %h/%b/%b",
                 n_checked, want.seq, want.reached, want.misuse,
                 got.seq, got.reached, got.misuse);
    end
    n_checked++;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input rsp_t exp);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= r.mode;
    in_ch.cpu_index <= r.cpu;
    in_ch.goal_seq  <= r.goal;
    in_ch.step_cost <= r.cost;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = clock_step(r);
    pending_results.push_back(typed ? exp : predicted);
    n_req++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reload(input budget_t value);
    drain();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.deferral_reload <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    clk_reload = value;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [erc_pkg::MODE_W-1:0] mode,
                         input int cpu, input seq_t goal, input budget_t cost,
                         input seq_t seq, input logic reached, input logic misuse);
    row_t row;
    row.kind        = kind;
    row.req.mode    = mode;
    row.req.cpu     = erc_pkg::CPU_IX_W'(cpu);
    row.req.goal    = goal;
    row.req.cost    = cost;
    row.exp.seq     = seq;
    row.exp.reached = reached;
    row.exp.misuse  = misuse;
    directed_rows.push_back(row);
  endtask

  // result sink: checks accepted items, drives ready with random stalls and the requested long hold
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        check_result('{out_ch.seq_value, out_ch.goal_reached, out_ch.misuse});
      if (hold_request && !hold_taken && hold_left == 0) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    req_t    r;
    int      count;
    budget_t phase_reload [NUM_PHASES];
    int      phase_idle [NUM_PHASES];
    int      phase_stall [NUM_PHASES];

    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= erc_pkg::MODE_ENTER;
    in_ch.cpu_index        <= '0;
    in_ch.goal_seq         <= '0;
    in_ch.step_cost        <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.deferral_reload <= '0;

    clk_write_seq = 1;
    clk_read_seq  = 1;
    clk_reload    = '0;
    for (int i = 0; i < NCPU; i++) begin
      clk_slot[i]   = '0;
      clk_budget[i] = '0;
    end
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    fail_count    = 0;
    n_checked     = 0;
    n_req         = 0;
    n_polls       = 0;
    n_reached     = 0;
    n_misuse      = 0;
    n_advances    = 0;

    phase_reload = '{32'hFFFF_FFFF, 32'd1, 32'd0, $urandom, 32'd5};
    phase_idle   = '{0, 62, 0, 36, 0};
    phase_stall  = '{0, 0, 62, 36, 0};

    add_row(ROW_TYPED, erc_pkg::MODE_POLL, 0, 32'h0, 32'h0, 32'd0, 1'b0, 1'b1);
    add_row(ROW_TYPED, erc_pkg::MODE_POLL, 0, 32'h1, 32'h0, 32'd0, 1'b1, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_POLL, 7, 32'hFFFF_FFFF, 32'h0, 32'd0, 1'b1, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_ENTER, 0, 32'h0, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_ENTER, 0, 32'h0, 32'h0, 32'd0, 1'b0, 1'b1);
    add_row(ROW_TYPED, erc_pkg::MODE_LEAVE, 7, 32'h0, 32'h0, 32'd0, 1'b0, 1'b1);
    add_row(ROW_TYPED, erc_pkg::MODE_ADVANCE, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'd3, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 0, 32'd3, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_LEAVE, 0, 32'h0, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 0, 32'd3, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_DEFERRED, 2, 32'h0, 32'h0, 32'd5, 1'b0, 1'b0);
    add_row(ROW_TYPED, erc_pkg::MODE_DEFERRED, 2, 32'h0, 32'hFFFF_FFFF,
            32'd5, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 3, 32'h8000_0005, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 3, 32'd7, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, MODE_RSVD5, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, MODE_RSVD6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    add_row(ROW_TYPED, MODE_RSVD7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_ENTER, 7, 32'h0, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_RELOAD, erc_pkg::MODE_ENTER, 0, 32'd3, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_DEFERRED, 1, 32'h0, 32'd5, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_DEFERRED, 1, 32'h0, 32'd2, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_DEFERRED, 1, 32'h0, 32'd1, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_DEFERRED, 1, 32'h0, 32'd1, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 0, 32'd11, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_POLL, 0, 32'd7, 32'h0, 32'd0, 1'b0, 1'b0);
    add_row(ROW_PREDICT, erc_pkg::MODE_LEAVE, 7, 32'h0, 32'h0, 32'd0, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_RELOAD)
        write_reload(directed_rows[k].req.goal);
      else
        send_req(directed_rows[k].req, directed_rows[k].kind == ROW_TYPED,
                 directed_rows[k].exp);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reload(phase_reload[ph]);
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      // last phase: long output stall while requests keep coming
      if (ph == NUM_PHASES - 1) hold_request = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        r = random_req();
        if (ph == 1 && count == PHASE_ITEMS / 2 && pending_results.size() != 0) drain();
        send_req(r, 1'b0, '0);
        if (r.mode <= erc_pkg::MODE_POLL) count++;
      end
    end

    drain();
    repeat (NCPU + 4) @(posedge clk);

    $display("covered %0d requests: %0d polls (%0d reached), %0d misuse, %0d clock advances",
             n_req, n_polls, n_reached, n_misuse, n_advances);
    $display("reload settings 0, 1, 3, 5, all-ones and random; idle/stall mixes; %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
